// ----- rtl/drum_step_sequencer_top_macros.svh -----
// ---------------------------------------------------------------------------
// Drum step sequencer assertion macros
// Shared concurrent assertion forms used by the sequencer RTL.
// ---------------------------------------------------------------------------
`ifndef DRUM_STEP_SEQUENCER_TOP_MACROS_SVH
`define DRUM_STEP_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/dss_pkg.sv -----
// ---------------------------------------------------------------------------
// Drum step sequencer package
// Constants, codes and shared types of the step sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dss_pkg;

   localparam int NUM_STEPS     = 16;
   localparam int STEP_W        = $clog2(NUM_STEPS);
   localparam int SUBSTEP_WIDTH = 6;
   localparam int NUM_VOICES    = 6;
   localparam int NUM_LEDS      = 2;
   localparam int TABLE_W       = NUM_VOICES * SUBSTEP_WIDTH;

   localparam int PATTERN_W  = 16;
   localparam int DIV_W      = 8;
   localparam int LED_MODE_W = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int CMD_W      = 2;
   localparam int VSEL_W     = 3;
   localparam int SSEL_W     = 4;
   localparam int BITS_W     = 6;
   localparam int TRIG_W     = 4;
   localparam int STEP_OUT_W = 4;

   localparam logic [PATTERN_W-1:0]     BEAT_RESET    = 16'h8000;
   localparam logic [SUBSTEP_WIDTH-1:0] SUBSTEP_RESET = SUBSTEP_WIDTH'(1) << (SUBSTEP_WIDTH - 1);
   localparam logic [DIV_W-1:0]         TICKS_RESET   = 8'd6;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_COMPARE = 2'd1,
      CMD_WRITE   = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PATTERN_SNARE   = 3'd0,
      REG_PATTERN_BASS    = 3'd1,
      REG_PATTERN_VOICE_A = 3'd2,
      REG_PATTERN_VOICE_B = 3'd3,
      REG_PATTERN_VOICE_C = 3'd4,
      REG_PATTERN_VOICE_D = 3'd5,
      REG_LED_OFF_MODE    = 3'd6,
      REG_TICKS_PER_STEP  = 3'd7
   } csr_reg_type;

   typedef enum logic [LED_MODE_W-1:0] {
      LED_OFF_ALWAYS  = 2'd0,
      LED_OFF_DIV_ONE = 2'd1,
      LED_OFF_NEVER   = 2'd2
   } led_mode_type;

   // Everything the second stage needs to finish one item.
   typedef struct packed {
      logic                     tick;
      logic                     clear;
      logic [NUM_VOICES-1:0]    pattern_hit;
      logic [SUBSTEP_WIDTH-1:0] sub_mask;
      logic [STEP_W-1:0]        step;
   } tick_info_type;

endpackage

// ----- rtl/dss_req_if.sv -----
// ---------------------------------------------------------------------------
// Sequencer request channel
// Valid/ready channel carrying one command beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dss_req_if;
   import dss_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic              playing;
   logic [VSEL_W-1:0] voice_select;
   logic [SSEL_W-1:0] step_select;
   logic [BITS_W-1:0] substep_bits;

   modport source (output valid, cmd, playing, voice_select, step_select, substep_bits,
                   input ready);
   modport sink   (input valid, cmd, playing, voice_select, step_select, substep_bits,
                   output ready);
endinterface

// ---------------------------------------------------------------------------

// ----- rtl/dss_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Sequencer response channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dss_rsp_if;
   import dss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [TRIG_W-1:0]     voice_triggers;
   logic [NUM_LEDS-1:0]   led_set;
   logic                  led_clear;
   logic [STEP_OUT_W-1:0] current_step;

   modport source (output valid, voice_triggers, led_set, led_clear, current_step,
                   input ready);
   modport sink   (input valid, voice_triggers, led_set, led_clear, current_step,
                   output ready);
endinterface

// ----- rtl/drum_step_sequencer_top.sv -----
// ---------------------------------------------------------------------------
// Drum step sequencer
// The block takes one command beat per cycle while the result side is not
// stalled and returns exactly one result beat for it through the stage-one
// and result registers. The substep table RAM is read in the accept cycle
// and its data is consumed as the beat leaves stage one. Step, divider and
// mask state update in the accept cycle, so consecutive ticks need no interlock.
// The substep table resets through per-entry valid bits and needs no clearing
// pass. Configuration is to be written while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "drum_step_sequencer_top_macros.svh"

module drum_step_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   dss_req_if.sink                        req,
   dss_rsp_if.source                      rsp,
   input  logic                           csr_we,
   input  logic [dss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dss_pkg::*;

   localparam int WA_W = STEP_W + SSEL_W;
   localparam int SB_W = SUBSTEP_WIDTH + BITS_W;
   localparam int SO_W = STEP_W + STEP_OUT_W;

   logic                  accept;
   logic                  s1_move;
   tick_info_type         info;
   logic                  wr_en;
   logic [WA_W-1:0]       wr_addr_ext;
   logic [SB_W-1:0]       wr_bits_ext;
   logic [TABLE_W-1:0]    entries;
   logic [NUM_VOICES-1:0] fired;
   logic [SO_W-1:0]       step_ext;

   logic                  s1_valid_ff, s1_valid_in;
   tick_info_type         s1_info_ff, s1_info_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TRIG_W-1:0]     trig_ff, trig_in;
   logic [NUM_LEDS-1:0]   led_set_ff, led_set_in;
   logic                  led_clear_ff, led_clear_in;
   logic [STEP_OUT_W-1:0] step_out_ff, step_out_in;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_move;
   assign accept    = req.valid && req.ready;

   dss_transport u_transport (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .cmd       (cmd_type'(req.cmd)),
      .playing   (req.playing),
      .info      (info)
   );

   assign wr_addr_ext = {{STEP_W{1'b0}}, req.step_select};
   assign wr_bits_ext = {{SUBSTEP_WIDTH{1'b0}}, req.substep_bits};
   assign wr_en = accept && (req.cmd == CMD_WRITE) &&
                  (req.voice_select < VSEL_W'(NUM_VOICES)) &&
                  (wr_addr_ext < WA_W'(NUM_STEPS));

   dss_table u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (info.tick),
      .rd_addr    (info.step),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr_ext[STEP_W-1:0]),
      .wr_voice   (req.voice_select),
      .wr_data    (wr_bits_ext[SUBSTEP_WIDTH-1:0]),
      .rd_entries (entries)
   );

   // Table data stays put while the second stage is stalled, since a new
   // read is only issued together with an accepted beat.
   always_comb begin
      for (int v = 0; v < NUM_VOICES; v++) begin
         fired[v] = s1_info_ff.tick && s1_info_ff.pattern_hit[v] &&
                    |(entries[v*SUBSTEP_WIDTH +: SUBSTEP_WIDTH] & s1_info_ff.sub_mask);
      end
   end

   assign step_ext = {{STEP_OUT_W{1'b0}}, s1_info_ff.step};

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !s1_move);
      s1_info_in   = accept ? info : s1_info_ff;
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp.ready);
      trig_in      = trig_ff;
      led_set_in   = led_set_ff;
      led_clear_in = led_clear_ff;
      step_out_in  = step_out_ff;
      if (s1_move) begin
         trig_in      = fired[NUM_VOICES-1:NUM_LEDS];
         led_set_in   = fired[NUM_LEDS-1:0];
         led_clear_in = s1_info_ff.clear;
         step_out_in  = step_ext[STEP_OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_info_ff   <= s1_info_in;
      trig_ff      <= trig_in;
      led_set_ff   <= led_set_in;
      led_clear_ff <= led_clear_in;
      step_out_ff  <= step_out_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.voice_triggers = trig_ff;
   assign rsp.led_set        = led_set_ff;
   assign rsp.led_clear      = led_clear_ff;
   assign rsp.current_step   = step_out_ff;

   `DSS_ASSERT_IMP(a_stall_holds_input, clock, reset, s1_valid_ff && rsp_valid_ff && !rsp.ready, !req.ready, "beat accepted into a stalled pipeline")
   `DSS_ASSERT_IMP(a_clear_excludes_hits, clock, reset, rsp_valid_ff && led_clear_ff, (led_set_ff == '0) && (trig_ff == '0), "LED clear together with a hit")
endmodule

// ----- rtl/dss_ram.sv -----
// ---------------------------------------------------------------------------
// Generic lane-writable RAM
// One write port with per-lane enables, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dss_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16,
   parameter int LANES = 6
) (
   input  logic                     clock,
   input  logic [LANES-1:0]         wr_lane_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   localparam int LANE_W = WIDTH / LANES;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (wr_lane_en[l]) begin
            mem_ff[wr_addr][l*LANE_W +: LANE_W] <= wr_data[l*LANE_W +: LANE_W];
         end
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/dss_table.sv -----
// ---------------------------------------------------------------------------
// Substep table
// Per-step substep entries in RAM, with per-entry valid bits for reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "drum_step_sequencer_top_macros.svh"

module dss_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [dss_pkg::STEP_W-1:0]        rd_addr,
   input  logic                              wr_en,
   input  logic [dss_pkg::STEP_W-1:0]        wr_addr,
   input  logic [dss_pkg::VSEL_W-1:0]        wr_voice,
   input  logic [dss_pkg::SUBSTEP_WIDTH-1:0] wr_data,
   output logic [dss_pkg::TABLE_W-1:0]       rd_entries
);
   import dss_pkg::*;

   logic [NUM_VOICES-1:0] valid_ff [NUM_STEPS];
   logic [NUM_VOICES-1:0] valid_in [NUM_STEPS];
   logic [NUM_VOICES-1:0] rd_valid_ff;
   logic [NUM_VOICES-1:0] rd_valid_in;
   logic [NUM_VOICES-1:0] lane_en;
   logic [TABLE_W-1:0]    ram_data;
   logic [TABLE_W-1:0]    valid_mask;

   always_comb begin
      lane_en = '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
         lane_en[v] = wr_en && (wr_voice == VSEL_W'(v));
      end
   end

   always_comb begin
      for (int s = 0; s < NUM_STEPS; s++) begin
         valid_in[s] = valid_ff[s];
      end
      if (wr_en) begin
         valid_in[wr_addr] = valid_ff[wr_addr] | lane_en;
      end
      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STEPS; s++) begin
            valid_ff[s] <= '0;
         end
         rd_valid_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STEPS; s++) begin
            valid_ff[s] <= valid_in[s];
         end
         rd_valid_ff <= rd_valid_in;
      end
   end

   dss_ram #(
      .WIDTH (TABLE_W),
      .DEPTH (NUM_STEPS),
      .LANES (NUM_VOICES)
   ) u_ram (
      .clock      (clock),
      .wr_lane_en (lane_en),
      .wr_addr    (wr_addr),
      .wr_data    ({NUM_VOICES{wr_data}}),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (ram_data)
   );

   // An entry never written since reset reads as zero.
   always_comb begin
      for (int v = 0; v < NUM_VOICES; v++) begin
         valid_mask[v*SUBSTEP_WIDTH +: SUBSTEP_WIDTH] = {SUBSTEP_WIDTH{rd_valid_ff[v]}};
      end
   end

   assign rd_entries = ram_data & valid_mask;

   `DSS_ASSERT_IMP(a_no_rd_wr_overlap, clock, reset, rd_en, !wr_en, "table read and write in one cycle")
endmodule

// ----- rtl/dss_transport.sv -----
// ---------------------------------------------------------------------------
// Sequencer transport
// Configuration registers, tick divider, step index and rotating masks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "drum_step_sequencer_top_macros.svh"

module dss_transport (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dss_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           accept,
   input  dss_pkg::cmd_type               cmd,
   input  logic                           playing,
   output dss_pkg::tick_info_type         info
);
   import dss_pkg::*;

   logic [PATTERN_W-1:0]     pattern_ff [NUM_VOICES];
   logic [PATTERN_W-1:0]     pattern_in [NUM_VOICES];
   logic [LED_MODE_W-1:0]    led_mode_ff, led_mode_in;
   logic [DIV_W-1:0]         ticks_ff, ticks_in;

   logic [DIV_W-1:0]         divider_ff, divider_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [PATTERN_W-1:0]     beat_ff, beat_in;
   logic [SUBSTEP_WIDTH-1:0] sub_ff, sub_in;

   logic [DIV_W-1:0]         div_inc;
   logic                     wrap;
   logic [STEP_W-1:0]        step_inc;
   logic                     play_tick;

   always_comb begin
      for (int v = 0; v < NUM_VOICES; v++) begin
         pattern_in[v] = pattern_ff[v];
      end
      led_mode_in = led_mode_ff;
      ticks_in    = ticks_ff;
      if (csr_we) begin
         if (csr_index == REG_LED_OFF_MODE) begin
            led_mode_in = csr_wdata[LED_MODE_W-1:0];
         end else if (csr_index == REG_TICKS_PER_STEP) begin
            ticks_in = csr_wdata[DIV_W-1:0];
         end else begin
            pattern_in[csr_index] = csr_wdata[PATTERN_W-1:0];
         end
      end
   end

   assign div_inc   = DIV_W'(divider_ff + 1'b1);
   // A limit of zero acts like one: the wrapped increment is always at least zero.
   assign wrap      = div_inc >= ticks_ff;
   assign step_inc  = (step_ff == STEP_W'(NUM_STEPS - 1)) ? '0 : STEP_W'(step_ff + 1'b1);
   assign play_tick = accept && (cmd == CMD_TICK) && playing;

   always_comb begin
      divider_in = divider_ff;
      step_in    = step_ff;
      beat_in    = beat_ff;
      sub_in     = sub_ff;
      if (play_tick) begin
         divider_in = wrap ? '0 : div_inc;
         if (wrap) begin
            step_in = step_inc;
            beat_in = {beat_ff[0], beat_ff[PATTERN_W-1:1]};
         end
         sub_in = {sub_ff[0], sub_ff[SUBSTEP_WIDTH-1:1]};
      end else if (accept && (cmd == CMD_TICK)) begin
         beat_in = BEAT_RESET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            pattern_ff[v] <= '0;
         end
         led_mode_ff <= '0;
         ticks_ff    <= TICKS_RESET;
         divider_ff  <= '0;
         step_ff     <= '0;
         beat_ff     <= BEAT_RESET;
         sub_ff      <= SUBSTEP_RESET;
      end else begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            pattern_ff[v] <= pattern_in[v];
         end
         led_mode_ff <= led_mode_in;
         ticks_ff    <= ticks_in;
         divider_ff  <= divider_in;
         step_ff     <= step_in;
         beat_ff     <= beat_in;
         sub_ff      <= sub_in;
      end
   end

   // Voices are matched against the beat after the step update and the
   // substep mask before its rotation.
   always_comb begin
      info.tick  = play_tick;
      info.clear = accept && (cmd == CMD_COMPARE) &&
                   ((led_mode_ff == LED_OFF_ALWAYS) ||
                    ((led_mode_ff == LED_OFF_DIV_ONE) && (divider_ff == DIV_W'(1))));
      for (int v = 0; v < NUM_VOICES; v++) begin
         info.pattern_hit[v] = |(pattern_ff[v] & beat_in);
      end
      info.sub_mask = sub_ff;
      info.step     = step_in;
   end

   `DSS_ASSERT_IMP(a_beat_onehot, clock, reset, 1'b1, $onehot(beat_ff), "beat mask not one-hot")
   `DSS_ASSERT_IMP(a_sub_onehot, clock, reset, 1'b1, $onehot(sub_ff), "substep mask not one-hot")
   `DSS_ASSERT_NEXT(a_wrap_clears, clock, reset, play_tick && wrap, divider_ff == '0, "divider not cleared on wrap")
endmodule

// ----- tb/sequencer_checker.sv -----
// ---------------------------------------------------------------------------
// Drum step sequencer result checker
// Watches the command, result and register ports, keeps its own copy of the
// sequencer state, predicts one result per accepted command beat and
// compares every result beat field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequencer_checker
   import dss_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dss_req_if                    req,
   dss_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [TRIG_W-1:0]     triggers;
      logic [NUM_LEDS-1:0]   leds;
      logic                  clear;
      logic [STEP_OUT_W-1:0] step;
   } step_outcome_type;

   // Register copies.
   logic [PATTERN_W-1:0]     hit_pattern [NUM_VOICES];
   logic [LED_MODE_W-1:0]    led_mode;
   logic [DIV_W-1:0]         step_limit;

   // Sequencer state copies.
   logic [DIV_W-1:0]         div_count;
   logic [STEP_W-1:0]        step_pos;
   logic [PATTERN_W-1:0]     beat_onehot;
   logic [SUBSTEP_WIDTH-1:0] sub_rotor;
   logic [SUBSTEP_WIDTH-1:0] sub_entries [NUM_STEPS][NUM_VOICES];

   step_outcome_type         awaited_outcomes [$];
   step_outcome_type         want;
   int                       result_count;

   task automatic report_mismatch(input string what);
      $display("[%0t] result %0d: %s", $time, result_count, what);
      mismatches++;
   endtask

   function automatic step_outcome_type advance_sequencer(input cmd_type op,
                                                          input logic play,
                                                          input logic [VSEL_W-1:0] voice,
                                                          input logic [SSEL_W-1:0] step,
                                                          input logic [BITS_W-1:0] bits);
      step_outcome_type      r;
      logic [NUM_VOICES-1:0] fired;
      r     = '0;
      fired = '0;
      case (op)
         CMD_TICK: begin
            if (play) begin
               div_count = div_count + 1'b1;
               // A limit of zero, or one lowered below the count, wraps at once.
               if (div_count >= step_limit) begin
                  div_count   = '0;
                  step_pos    = (step_pos == NUM_STEPS - 1) ? '0 : step_pos + 1'b1;
                  beat_onehot = {beat_onehot[0], beat_onehot[PATTERN_W-1:1]};
               end
               for (int v = 0; v < NUM_VOICES; v++) begin
                  if ((hit_pattern[v] & beat_onehot) != 0 &&
                      (sub_entries[step_pos][v] & sub_rotor) != 0)
                     fired[v] = 1'b1;
               end
               r.leds     = fired[NUM_LEDS-1:0];
               r.triggers = fired[NUM_VOICES-1:NUM_LEDS];
               sub_rotor  = {sub_rotor[0], sub_rotor[SUBSTEP_WIDTH-1:1]};
            end else begin
               beat_onehot = BEAT_RESET;
            end
         end
         CMD_COMPARE: begin
            // Mode three falls through to never clearing.
            r.clear = (led_mode == LED_OFF_ALWAYS) ||
                      (led_mode == LED_OFF_DIV_ONE && div_count == 1);
         end
         CMD_WRITE: begin
            if (voice < NUM_VOICES)
               sub_entries[step][voice] = bits[SUBSTEP_WIDTH-1:0];
         end
         default: ;
      endcase
      r.step = step_pos;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < NUM_VOICES; v++) begin
            hit_pattern[v] = '0;
            for (int s = 0; s < NUM_STEPS; s++)
               sub_entries[s][v] = '0;
         end
         led_mode     = '0;
         step_limit   = TICKS_RESET;
         div_count    = '0;
         step_pos     = '0;
         beat_onehot  = BEAT_RESET;
         sub_rotor    = SUBSTEP_RESET;
         mismatches   = 0;
         result_count = 0;
         awaited_outcomes.delete();
      end else begin
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_LED_OFF_MODE:   led_mode   = csr_wdata[LED_MODE_W-1:0];
               REG_TICKS_PER_STEP: step_limit = csr_wdata[DIV_W-1:0];
               default:            hit_pattern[csr_index] = csr_wdata[PATTERN_W-1:0];
            endcase
         end
         if (req.valid && req.ready)
            awaited_outcomes.push_back(advance_sequencer(cmd_type'(req.cmd), req.playing,
                                                         req.voice_select, req.step_select,
                                                         req.substep_bits));
         if (rsp.valid && rsp.ready) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("result beat arrived with no command outstanding");
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp.voice_triggers !== want.triggers)
                  report_mismatch($sformatf("voice_triggers %h, predicted %h",
                                            rsp.voice_triggers, want.triggers));
               if (rsp.led_set !== want.leds)
                  report_mismatch($sformatf("led_set %h, predicted %h",
                                            rsp.led_set, want.leds));
               if (rsp.led_clear !== want.clear)
                  report_mismatch($sformatf("led_clear %b, predicted %b",
                                            rsp.led_clear, want.clear));
               if (rsp.current_step !== want.step)
                  report_mismatch($sformatf("current_step %0d, predicted %0d",
                                            rsp.current_step, want.step));
            end
            result_count++;
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// Drum step sequencer testbench
// Drives directed and random command beats through the sequencer under
// several sender idle and receiver stall mixes, rewriting the registers
// between phases, and reports the checker's verdict at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import dss_pkg::*;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    outstanding;
   int                    send_idle_pct;
   int                    stall_pct;

   dss_req_if req_ch ();
   dss_rsp_if rsp_ch ();

   drum_step_sequencer_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sequencer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // All tasks below start and end at a falling edge.
   task automatic issue_command(input cmd_type op, input logic play,
                                input logic [VSEL_W-1:0] voice,
                                input logic [SSEL_W-1:0] step,
                                input logic [BITS_W-1:0] bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= op;
      req_ch.playing      <= play;
      req_ch.voice_select <= voice;
      req_ch.step_select  <= step;
      req_ch.substep_bits <= bits;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Lowers valid and waits until every result beat has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic end_writes();
      csr_we <= 1'b0;
   endtask

   task automatic pick_settings();
      logic [PATTERN_W-1:0] pat;
      logic [DIV_W-1:0]     limit;
      for (int k = 0; k < NUM_VOICES; k++) begin
         case ($urandom_range(5))
            0:       pat = '0;
            1:       pat = '1;
            default: pat = PATTERN_W'($urandom);
         endcase
         write_reg(csr_reg_type'(k), pat);
      end
      write_reg(REG_LED_OFF_MODE, CSR_DATA_W'($urandom_range(3)));
      case ($urandom_range(7))
         0:       limit = 8'd0;
         1:       limit = 8'd255;
         2:       limit = 8'd1;
         default: limit = DIV_W'($urandom_range(2, 8));
      endcase
      write_reg(REG_TICKS_PER_STEP, CSR_DATA_W'(limit));
      end_writes();
   endtask

   // Mostly playing ticks so the step and masks keep moving, with enough
   // table writes to make voices fire.
   task automatic random_command();
      int                roll;
      cmd_type           op;
      logic              play;
      logic [VSEL_W-1:0] voice;
      roll  = $urandom_range(99);
      voice = ($urandom_range(9) == 0) ? VSEL_W'($urandom_range(7, NUM_VOICES))
                                       : VSEL_W'($urandom_range(NUM_VOICES - 1));
      play  = 1'($urandom);
      if (roll < 60) begin
         op   = CMD_TICK;
         play = 1'b1;
      end else if (roll < 68) begin
         op   = CMD_TICK;
         play = 1'b0;
      end else if (roll < 80) begin
         op = CMD_COMPARE;
      end else if (roll < 95) begin
         op = CMD_WRITE;
      end else begin
         op = CMD_NOP;
      end
      issue_command(op, play, voice, SSEL_W'($urandom), BITS_W'($urandom));
   endtask

   initial begin
      int send_mix  [4] = '{0, 47, 0, 22};
      int stall_mix [4] = '{0, 0, 47, 22};
      clock               = 1'b0;
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_TICK;
      req_ch.playing      = 1'b0;
      req_ch.voice_select = '0;
      req_ch.step_select  = '0;
      req_ch.substep_bits = '0;
      rsp_ch.ready        = 1'b0;
      send_idle_pct       = 0;
      stall_pct           = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Every voice plays on every step, and the step advances on each tick.
      for (int k = 0; k < NUM_VOICES; k++)
         write_reg(csr_reg_type'(k), 16'hFFFF);
      write_reg(REG_LED_OFF_MODE, CSR_DATA_W'(LED_OFF_ALWAYS));
      write_reg(REG_TICKS_PER_STEP, 16'd1);
      end_writes();
      for (int k = 0; k < NUM_VOICES; k++)
         issue_command(CMD_WRITE, 1'b0, VSEL_W'(k), 4'd1, 6'h3F);
      issue_command(CMD_WRITE, 1'b1, 3'd6, 4'd1, 6'h3F);
      issue_command(CMD_WRITE, 1'b0, 3'd7, 4'd15, 6'h00);
      issue_command(CMD_TICK, 1'b1, 3'd7, 4'd15, 6'h3F);
      issue_command(CMD_TICK, 1'b1, 3'd0, 4'd0, 6'h00);
      issue_command(CMD_COMPARE, 1'b1, 3'd0, 4'd0, 6'h00);
      issue_command(CMD_NOP, 1'b1, 3'd7, 4'd15, 6'h3F);
      issue_command(CMD_TICK, 1'b0, 3'd0, 4'd0, 6'h00);
      drain();

      // A zero limit behaves like one; compare clears only at divider one.
      write_reg(REG_TICKS_PER_STEP, 16'd0);
      write_reg(REG_LED_OFF_MODE, CSR_DATA_W'(LED_OFF_DIV_ONE));
      end_writes();
      issue_command(CMD_TICK, 1'b1, 3'd0, 4'd0, 6'h00);
      issue_command(CMD_COMPARE, 1'b0, 3'd0, 4'd0, 6'h00);
      drain();

      // Largest limit, then lowered below the count so the next tick wraps.
      write_reg(REG_TICKS_PER_STEP, 16'd255);
      write_reg(REG_LED_OFF_MODE, 16'd3);
      end_writes();
      repeat (3) issue_command(CMD_TICK, 1'b1, 3'd0, 4'd0, 6'h00);
      issue_command(CMD_COMPARE, 1'b1, 3'd0, 4'd0, 6'h00);
      drain();
      write_reg(REG_TICKS_PER_STEP, 16'd2);
      write_reg(REG_LED_OFF_MODE, CSR_DATA_W'(LED_OFF_DIV_ONE));
      end_writes();
      issue_command(CMD_TICK, 1'b1, 3'd0, 4'd0, 6'h00);
      issue_command(CMD_TICK, 1'b1, 3'd0, 4'd0, 6'h00);
      issue_command(CMD_COMPARE, 1'b1, 3'd0, 4'd0, 6'h00);
      drain();
      write_reg(REG_LED_OFF_MODE, CSR_DATA_W'(LED_OFF_NEVER));
      end_writes();
      issue_command(CMD_COMPARE, 1'b0, 3'd0, 4'd0, 6'h00);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_mix[phase];
         stall_pct     = stall_mix[phase];
         repeat (2) begin
            pick_settings();
            repeat (56) random_command();
            drain();
         end
      end

      stall_pct = 0;
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
